FILE: design/fpr_pkg.sv
package fpr_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FIELD_WIDTH = 32;
  localparam int COUNT_WIDTH = $clog2(DATA_WIDTH);

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  busy;
    logic  done;
    word_t quotient;
    word_t remainder;
  } div_rsp_t;

  localparam word_t WORD_ONE = word_t'(1);

  // The 32-bit fields are sign-extended, or cut down, to the working width.
  function automatic word_t widen(input logic [FIELD_WIDTH-1:0] v);
    return word_t'($signed(v));
  endfunction

  function automatic word_t magnitude(input word_t v);
    return v[DATA_WIDTH-1] ? word_t'(0) - v : v;
  endfunction

endpackage

FILE: design/fpr_divider.sv
module fpr_divider (
  input  logic              clk,
  input  logic              rst,
  input  fpr_pkg::div_req_t req,
  output fpr_pkg::div_rsp_t rsp
);

  logic                           busy;
  logic                           done;
  logic [fpr_pkg::COUNT_WIDTH-1:0] cnt;
  fpr_pkg::word_t                 rem;
  fpr_pkg::word_t                 quo;
  fpr_pkg::word_t                 dvs;
  logic                           q_neg;
  logic                           r_neg;
  logic [fpr_pkg::DATA_WIDTH:0]   shifted;
  logic [fpr_pkg::DATA_WIDTH:0]   trial;

  assign shifted = {rem, quo[fpr_pkg::DATA_WIDTH-1]};
  assign trial   = shifted - {1'b0, dvs};

  // Restoring divide on magnitudes, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (req.start) begin
        busy <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      cnt <= cnt - 1'b1;
      if (!trial[fpr_pkg::DATA_WIDTH]) begin
        rem <= trial[fpr_pkg::DATA_WIDTH-1:0];
        quo <= {quo[fpr_pkg::DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem <= shifted[fpr_pkg::DATA_WIDTH-1:0];
        quo <= {quo[fpr_pkg::DATA_WIDTH-2:0], 1'b0};
      end
    end else if (req.start) begin
      cnt   <= fpr_pkg::COUNT_WIDTH'(fpr_pkg::DATA_WIDTH - 1);
      rem   <= '0;
      quo   <= fpr_pkg::magnitude(req.dividend);
      dvs   <= fpr_pkg::magnitude(req.divisor);
      q_neg <= req.dividend[fpr_pkg::DATA_WIDTH-1] ^ req.divisor[fpr_pkg::DATA_WIDTH-1];
      r_neg <= req.dividend[fpr_pkg::DATA_WIDTH-1];
    end
  end

  // Truncating division: the quotient sign is the xor of the operand signs
  // and the remainder follows the dividend. Negation wraps, so the minimum
  // value divided by minus one comes back as the minimum value.
  assign rsp.busy      = busy;
  assign rsp.done      = done;
  assign rsp.quotient  = q_neg ? fpr_pkg::word_t'(0) - quo : quo;
  assign rsp.remainder = r_neg ? fpr_pkg::word_t'(0) - rem : rem;

endmodule

FILE: design/fraction_product_reduce.sv
// Multiplies a stream of signed fractions into a running numerator and
// denominator (both starting at 1/1 and wrapping in two's complement), and on
// the item marked last reduces the product by Euclid's gcd with truncating
// remainder, emits it and restarts at 1/1. An item with last low only updates
// the running products. An item with last high is multiplied, then each Euclid
// step is a check state plus one division on a single shared radix-2 divider,
// then come the final check, the two quotient divisions and the emit cycle;
// in_ready is low meanwhile. When both products are zero the gcd is zero and
// the raw products are emitted with zero_gcd_error set, after the check state.
// A finished result waits in the output register while the next set is
// accumulated, and the emit cycle repeats while an earlier result is unread.
module fraction_product_reduce (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] numerator,
  input  logic signed [31:0] denominator,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] product_numerator,
  output logic signed [31:0] product_denominator,
  output logic               zero_gcd_error
);

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_GCD_CHECK = 6'b000010,
    S_GCD_DIV   = 6'b000100,
    S_QUOT_NUM  = 6'b001000,
    S_QUOT_DEN  = 6'b010000,
    S_EMIT      = 6'b100000
  } state_t;

  state_t            state;
  fpr_pkg::word_t    run_num;
  fpr_pkg::word_t    run_den;
  fpr_pkg::word_t    prod_num;
  fpr_pkg::word_t    prod_den;
  fpr_pkg::word_t    ga;
  fpr_pkg::word_t    gb;
  fpr_pkg::word_t    res_num;
  fpr_pkg::word_t    res_den;
  logic              res_err;
  fpr_pkg::div_req_t div_req;
  fpr_pkg::div_rsp_t div_rsp;
  logic              in_fire;
  logic              out_free;

  fpr_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign prod_num = fpr_pkg::word_t'(run_num * fpr_pkg::widen(numerator));
  assign prod_den = fpr_pkg::word_t'(run_den * fpr_pkg::widen(denominator));

  always_comb begin
    div_req = '0;
    case (state)
      S_GCD_CHECK: begin
        if (gb != '0) begin
          div_req.start    = 1'b1;
          div_req.dividend = ga;
          div_req.divisor  = gb;
        end else if (ga != '0) begin
          div_req.start    = 1'b1;
          div_req.dividend = run_num;
          div_req.divisor  = ga;
        end
      end
      S_QUOT_NUM: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = run_den;
          div_req.divisor  = ga;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      run_num <= fpr_pkg::WORD_ONE;
      run_den <= fpr_pkg::WORD_ONE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            run_num <= prod_num;
            run_den <= prod_den;
            if (last) begin
              state <= S_GCD_CHECK;
            end
          end
        end
        S_GCD_CHECK: begin
          if (gb != '0) begin
            state <= S_GCD_DIV;
          end else if (ga != '0) begin
            state <= S_QUOT_NUM;
          end else begin
            state <= S_EMIT;
          end
        end
        S_GCD_DIV: begin
          if (div_rsp.done) begin
            state <= S_GCD_CHECK;
          end
        end
        S_QUOT_NUM: begin
          if (div_rsp.done) begin
            state <= S_QUOT_DEN;
          end
        end
        S_QUOT_DEN: begin
          if (div_rsp.done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            run_num <= fpr_pkg::WORD_ONE;
            run_den <= fpr_pkg::WORD_ONE;
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Euclid operands and the reduced result.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          ga <= prod_num;
          gb <= prod_den;
        end
      end
      S_GCD_CHECK: begin
        // Both products zero leaves the gcd at zero: pass them through raw.
        res_err <= (gb == '0) && (ga == '0);
        res_num <= run_num;
        res_den <= run_den;
      end
      S_GCD_DIV: begin
        if (div_rsp.done) begin
          ga <= gb;
          gb <= div_rsp.remainder;
        end
      end
      S_QUOT_NUM: begin
        if (div_rsp.done) begin
          res_num <= div_rsp.quotient;
        end
      end
      S_QUOT_DEN: begin
        if (div_rsp.done) begin
          res_den <= div_rsp.quotient;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      product_numerator   <= 32'(res_num);
      product_denominator <= 32'(res_den);
      zero_gcd_error      <= res_err;
    end
  end

endmodule

FILE: test/fraction_product_reduce_tb.sv
module fraction_product_reduce_tb;

  localparam int CLK_HALF = 5;
  localparam int CYCLE_LIMIT = 8_000_000;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct {
    logic signed [31:0] num;
    logic signed [31:0] den;
    logic               zero_gcd;
  } reduced_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] numerator;
  logic signed [31:0] denominator;
  logic               last;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] product_numerator;
  logic signed [31:0] product_denominator;
  logic               zero_gcd_error;

  // Running products of the current set, as the block should hold them.
  fpr_pkg::word_t acc_num;
  fpr_pkg::word_t acc_den;
  reduced_t       pending_products[$];

  bit          sender_gaps;
  bit          receiver_stalls;
  int          hold_cycles;
  int unsigned failures;
  int unsigned cycle_count;
  int unsigned fractions_sent;
  int unsigned products_checked;
  int unsigned zero_gcd_seen;

  fraction_product_reduce i_dut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .numerator           (numerator),
    .denominator         (denominator),
    .last                (last),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .product_numerator   (product_numerator),
    .product_denominator (product_denominator),
    .zero_gcd_error      (zero_gcd_error)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d products outstanding", $time, pending_products.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic fpr_pkg::word_t abs_word(input fpr_pkg::word_t v);
    return v[fpr_pkg::DATA_WIDTH-1] ? fpr_pkg::word_t'(0) - v : v;
  endfunction

  // Quotient truncated toward zero; the minimum value over -1 wraps back to itself.
  function automatic fpr_pkg::word_t trunc_quot(input fpr_pkg::word_t a,
                                                input fpr_pkg::word_t b);
    fpr_pkg::word_t q;
    q = abs_word(a) / abs_word(b);
    return (a[fpr_pkg::DATA_WIDTH-1] != b[fpr_pkg::DATA_WIDTH-1]) ?
           fpr_pkg::word_t'(0) - q : q;
  endfunction

  function automatic logic [31:0] pick_field(input bit zero_ok);
    logic [31:0] v;
    case ($urandom_range(0, 9)) inside
      [0:3]: v = $urandom_range(0, 40) - 20;
      [4:6]: v = $urandom();
      7: begin
        case ($urandom_range(0, 5))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7fff_ffff;
          2:       v = 32'hffff_ffff;
          3:       v = 32'h0000_0001;
          4:       v = 32'h0000_0000;
          default: v = 32'h1 << $urandom_range(0, 31);
        endcase
      end
      default: begin
        // Values with many shared small factors make the gcd loop do real work.
        v = $urandom_range(1, 12) * $urandom_range(1, 12) * (32'd1 << $urandom_range(0, 6));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    if (!zero_ok && v == 32'h0) v = 32'h1;
    return v;
  endfunction

  task automatic send_fraction(input logic signed [31:0] n, input logic signed [31:0] d,
                               input logic l);
    fpr_pkg::word_t a;
    fpr_pkg::word_t b;
    fpr_pkg::word_t r;
    fpr_pkg::word_t rn;
    fpr_pkg::word_t rd;
    reduced_t       prod;
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    numerator   <= n;
    denominator <= d;
    last        <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    fractions_sent++;

    acc_num = acc_num * fpr_pkg::word_t'(n);
    acc_den = acc_den * fpr_pkg::word_t'(d);
    if (l) begin
      // Euclid with a truncating remainder, so the gcd may come out negative.
      a = acc_num;
      b = acc_den;
      while (b != fpr_pkg::word_t'(0)) begin
        r = abs_word(a) % abs_word(b);
        if (a[fpr_pkg::DATA_WIDTH-1]) r = fpr_pkg::word_t'(0) - r;
        a = b;
        b = r;
      end
      prod.zero_gcd = (a == fpr_pkg::word_t'(0));
      if (prod.zero_gcd) begin
        rn = acc_num;
        rd = acc_den;
      end else begin
        rn = trunc_quot(acc_num, a);
        rd = trunc_quot(acc_den, a);
      end
      prod.num = rn[31:0];
      prod.den = rd[31:0];
      pending_products.push_back(prod);
      acc_num = fpr_pkg::WORD_ONE;
      acc_den = fpr_pkg::WORD_ONE;
    end
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_products.size() != 0);
    @(negedge clk);
  endtask

  task automatic send_random_set(input int max_len);
    int len;
    len = $urandom_range(1, max_len);
    for (int i = 0; i < len; i++)
      send_fraction(pick_field(1'b1), pick_field($urandom_range(0, 49) == 0), i == len - 1);
  endtask

  task automatic test_directed_cases();
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    send_fraction(1, 1, 1'b1);
    send_fraction(0, 5, 1'b1);
    send_fraction(6, -4, 1'b1);
    send_fraction(-6, 4, 1'b1);
    send_fraction(-12, -18, 1'b1);
    // The minimum value against -1: zero remainder, and a quotient that wraps.
    send_fraction(32'sh8000_0000, -1, 1'b1);
    send_fraction(32'sh8000_0000, 32'sh7fff_ffff, 1'b1);
    send_fraction(32'sh7fff_ffff, 32'sh8000_0000, 1'b1);
    send_fraction(32'sh7fff_ffff, 32'sh7fff_ffff, 1'b1);
    send_fraction(32'sh8000_0000, 32'sh8000_0000, 1'b1);
    send_fraction(-1, -1, 1'b1);
    // Both products zero, in one item and spread over two.
    send_fraction(0, 0, 1'b1);
    send_fraction(0, 7, 1'b0);
    send_fraction(9, 0, 1'b1);
    // A zero denominator alone makes the gcd equal the numerator product.
    send_fraction(5, 0, 1'b1);
    send_fraction(65536, 3, 1'b0);
    send_fraction(65536, 3, 1'b1);
    send_fraction(7, 3, 1'b0);
    send_fraction(3, 7, 1'b1);
    send_fraction(32'sh7fff_ffff, 1, 1'b0);
    send_fraction(32'sh7fff_ffff, 1, 1'b1);
    wait_drain();
  endtask

  task automatic test_random_sets(input int n_items);
    int unsigned first;
    int          sets;
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    first = fractions_sent;
    sets  = 0;
    while (fractions_sent - first < n_items) begin
      send_random_set(($urandom_range(0, 9) == 0) ? 12 : 4);
      sets++;
      // Now and then let the pipeline empty completely before going on.
      if (sets % 50 == 0) wait_drain();
    end
    wait_drain();
  endtask

  task automatic test_output_backpressure(input int n_items);
    int unsigned first;
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    hold_cycles     = HOLD_OFF_CYCLES;
    first = fractions_sent;
    while (fractions_sent - first < n_items) send_random_set(2);
    wait_drain();
  endtask

  task automatic test_steady_stream(input int n_items);
    int unsigned first;
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    first = fractions_sent;
    while (fractions_sent - first < n_items) send_random_set(4);
    wait_drain();
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles - 1) @(negedge clk);
        hold_cycles = 0;
      end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 18)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string label, input logic signed [31:0] want_v,
                             input logic signed [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want_v, got_v);
      failures++;
    end
  endtask

  always @(posedge clk) begin : result_check
    reduced_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_products.size() == 0) begin
        $display("%0t: unexpected product: expected none, actual %0d/%0d flag %0b",
                 $time, product_numerator, product_denominator, zero_gcd_error);
        failures++;
      end else begin
        want = pending_products.pop_front();
        check_field("product_numerator", want.num, product_numerator);
        check_field("product_denominator", want.den, product_denominator);
        check_field("zero_gcd_error", 32'(want.zero_gcd), 32'(zero_gcd_error));
        products_checked++;
        if (want.zero_gcd) zero_gcd_seen++;
      end
    end
  end

  initial begin
    rst              = 1'b1;
    in_valid         = 1'b0;
    numerator        = '0;
    denominator      = '0;
    last             = 1'b0;
    sender_gaps      = 1'b0;
    receiver_stalls  = 1'b0;
    hold_cycles      = 0;
    failures         = 0;
    cycle_count      = 0;
    fractions_sent   = 0;
    products_checked = 0;
    zero_gcd_seen    = 0;
    acc_num          = fpr_pkg::WORD_ONE;
    acc_den          = fpr_pkg::WORD_ONE;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_random_sets(820);
    test_output_backpressure(40);
    test_steady_stream(170);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_products.size() != 0) begin
      $display("%0t: %0d products never arrived", $time, pending_products.size());
      failures++;
    end
    $display("Sent %0d fractions; checked %0d reduced products, %0d of them with a zero gcd.",
             fractions_sent, products_checked, zero_gcd_seen);
    $display("Run included idle bursts on both sides, a %0d-cycle output hold and full drains.",
             HOLD_OFF_CYCLES);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
design/fpr_pkg.sv
design/fpr_divider.sv
design/fraction_product_reduce.sv
test/fraction_product_reduce_tb.sv
